// File: design/lwm_pkg.sv
// package for the sql like wildcard matcher
// holds item types, action and entry kind codes, and the pattern classifier
// used by lwm_pattern_store, lwm_position_engine and sql_like_wildcard_matcher
`default_nettype none

package lwm_pkg;

	localparam int PATTERN_MAX_DEF = 32;
	localparam logic [7:0] ESC_RESET = 8'd92;
	localparam logic [7:0] CHAR_RUN = 8'h25;
	localparam logic [7:0] CHAR_ONE = 8'h5F;

	typedef enum logic [1:0] {
		ACT_CLEAR   = 2'd0,
		ACT_PATTERN = 2'd1,
		ACT_TEXT    = 2'd2,
		ACT_END     = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		KIND_LIT = 2'd0,
		KIND_ONE = 2'd1,
		KIND_RUN = 2'd2
	} kind_t;

	typedef struct packed {
		action_t    action;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic matched;
		logic pattern_overflow;
	} result_t;

	typedef struct packed {
		logic       clear;
		logic       append;
		logic [7:0] data;
	} store_cmd_t;

	typedef struct packed {
		logic clear;
		logic text;
		logic finish;
	} pos_cmd_t;

	function automatic kind_t classify(input logic [7:0] b);
		kind_t k;
		k = KIND_LIT;
		if (b == CHAR_RUN)
			k = KIND_RUN;
		else if (b == CHAR_ONE)
			k = KIND_ONE;
		return k;
	endfunction

endpackage

`default_nettype wire

// File: design/lwm_pattern_store.sv
// compiled pattern store: entry kinds and bytes, length, pending escape, overflow
// presents per-position run and advance vectors for the current text byte
// depends on lwm_pkg
`default_nettype none

module lwm_pattern_store import lwm_pkg::*; #(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF,
	parameter int LW = $clog2(PATTERN_MAX + 1)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire store_cmd_t             cmd,
	input  wire logic [7:0]             esc,
	output logic [PATTERN_MAX-1:0]      run_vec,
	output logic [PATTERN_MAX-1:0]      adv_vec,
	output logic [LW-1:0]               eff_len,
	output logic                        overflow
);

	localparam int IW = $clog2(PATTERN_MAX);

	kind_t      kind_q [PATTERN_MAX];
	logic [7:0] byte_q [PATTERN_MAX];
	logic [LW-1:0] len_q;
	logic          pend_q;
	logic          ovf_q;

	logic [LW-1:0] len_d;
	logic          pend_d;
	logic          ovf_d;
	logic          wr_en;
	kind_t         wr_kind;
	logic [IW-1:0] wr_idx;

	// a pending escape only exists while len_q is below the store size
	assign wr_idx = len_q[IW-1:0];

	always_comb begin
		wr_en = 1'b0;
		wr_kind = KIND_LIT;
		len_d = len_q;
		pend_d = pend_q;
		ovf_d = ovf_q;
		if (cmd.clear) begin
			len_d = '0;
			pend_d = 1'b0;
			ovf_d = 1'b0;
		end else if (cmd.append) begin
			if (pend_q) begin
				// escaped byte overwrites the escape entry as a literal
				wr_en = 1'b1;
				wr_kind = KIND_LIT;
				len_d = LW'(len_q + 1'b1);
				pend_d = 1'b0;
			end else if (len_q >= LW'(PATTERN_MAX)) begin
				ovf_d = 1'b1;
			end else begin
				wr_en = 1'b1;
				wr_kind = classify(cmd.data);
				if (cmd.data == esc)
					pend_d = 1'b1;
				else
					len_d = LW'(len_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			pend_q <= 1'b0;
			ovf_q <= 1'b0;
		end else begin
			len_q <= len_d;
			pend_q <= pend_d;
			ovf_q <= ovf_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			kind_q[wr_idx] <= wr_kind;
			byte_q[wr_idx] <= cmd.data;
		end
	end

	// a trailing escape counts as one more entry
	assign eff_len = LW'(len_q + LW'(pend_q));
	assign overflow = ovf_q;

	always_comb begin
		logic vld;
		for (int i = 0; i < PATTERN_MAX; i++) begin
			vld = LW'(i) < eff_len;
			run_vec[i] = vld && (kind_q[i] == KIND_RUN);
			adv_vec[i] = vld && (kind_q[i] != KIND_RUN)
				&& ((kind_q[i] == KIND_ONE) || (byte_q[i] == cmd.data));
		end
	end

endmodule

`default_nettype wire

// File: design/lwm_position_engine.sv
// active position set with closure over run entries and the per-byte step
// closure is one carry-chain add over the position vector
// depends on lwm_pkg
`default_nettype none

module lwm_position_engine import lwm_pkg::*; #(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF,
	parameter int LW = $clog2(PATTERN_MAX + 1)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire pos_cmd_t               cmd,
	input  wire logic [PATTERN_MAX-1:0] run_vec,
	input  wire logic [PATTERN_MAX-1:0] adv_vec,
	input  wire logic [LW-1:0]          eff_len,
	output logic                        matched
);

	logic [PATTERN_MAX:0]   act_q;
	logic [PATTERN_MAX:0]   len_mask;
	logic [PATTERN_MAX:0]   cur;
	logic [PATTERN_MAX-1:0] gen;
	logic [PATTERN_MAX:0]   sum;
	logic [PATTERN_MAX:0]   carry;
	logic [PATTERN_MAX:0]   closed;
	logic [PATTERN_MAX:0]   nxt;

	always_comb begin
		for (int j = 0; j <= PATTERN_MAX; j++)
			len_mask[j] = LW'(j) <= eff_len;
	end

	// carry into position j is set when an active run entry reaches it
	// through a chain of run entries
	assign cur = act_q & len_mask;
	assign gen = cur[PATTERN_MAX-1:0] & run_vec;
	assign sum = {1'b0, gen} + {1'b0, run_vec};
	assign carry = sum ^ {1'b0, gen ^ run_vec};
	assign closed = cur | carry;

	assign nxt = {1'b0, closed[PATTERN_MAX-1:0] & run_vec}
		| {closed[PATTERN_MAX-1:0] & adv_vec, 1'b0};

	assign matched = closed[eff_len];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= (PATTERN_MAX+1)'(1);
		end else if (cmd.clear || cmd.finish) begin
			act_q <= (PATTERN_MAX+1)'(1);
		end else if (cmd.text) begin
			act_q <= nxt;
		end
	end

endmodule

`default_nettype wire

// File: design/sql_like_wildcard_matcher.sv
// top level of the sql like wildcard matcher
// input register, pattern store, position engine and result register
// depends on lwm_pkg, lwm_pattern_store, lwm_position_engine
//
// usage:
//   req channel (req_valid, req_stall, req) carries one item: an action and a
//   byte. clear resets the pattern, pattern appends a pattern byte, text steps
//   the active position set, end reports the match and restarts the text.
//   rsp channel (rsp_valid, rsp_stall, rsp) carries one result per end item:
//   matched and pattern_overflow.
//   cfg channel (cfg_valid, cfg_ready, cfg_data) writes the escape byte; it is
//   always ready and should be written only while no item is in flight.
// timing:
//   an item is taken into the input register and processed from there; an end
//   item waits there while the result register is blocked. its result goes
//   from the input register into the result register, where it is shown.
//   one item per cycle is sustained unless a result is blocked; the position
//   update for a text byte is a single carry-chain add over the position vector.
// reset: pattern empty, no pending escape, overflow clear, only position zero
//   active, escape byte 92.
// stall: a result held in the output register under rsp_stall blocks only an
//   end item waiting behind it, which then stalls the req channel.
`default_nettype none

module sql_like_wildcard_matcher import lwm_pkg::*; #(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_stall,
	input  wire item_t      req,
	output logic            rsp_valid,
	input  wire logic       rsp_stall,
	output result_t         rsp,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_data
);

	localparam int LW = $clog2(PATTERN_MAX + 1);

	logic       vld_s1;
	item_t      item_s1;
	logic       rsp_valid_q;
	result_t    rsp_q;
	logic [7:0] esc_q;

	logic produce;
	logic out_free;
	logic adv_s1;
	logic accept;

	store_cmd_t st_cmd;
	pos_cmd_t   pos_cmd;

	logic [PATTERN_MAX-1:0] run_vec;
	logic [PATTERN_MAX-1:0] adv_vec;
	logic [LW-1:0]          eff_len;
	logic                   ovf;
	logic                   matched;

	assign produce = vld_s1 && (item_s1.action == ACT_END);
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign adv_s1 = vld_s1 && (!produce || out_free);
	assign req_stall = vld_s1 && !adv_s1;
	assign accept = req_valid && !req_stall;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q <= ESC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			esc_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (adv_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= req;
	end

	always_comb begin
		st_cmd = '0;
		pos_cmd = '0;
		st_cmd.data = item_s1.data_byte;
		case (item_s1.action)
			ACT_CLEAR: begin
				st_cmd.clear = adv_s1;
				pos_cmd.clear = adv_s1;
			end
			ACT_PATTERN: begin
				st_cmd.append = adv_s1;
			end
			ACT_TEXT: begin
				pos_cmd.text = adv_s1;
			end
			ACT_END: begin
				pos_cmd.finish = adv_s1;
			end
			default: begin
				st_cmd.clear = 1'b0;
			end
		endcase
	end

	lwm_pattern_store #(
		.PATTERN_MAX(PATTERN_MAX),
		.LW(LW)
	) u_store (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(st_cmd),
		.esc(esc_q),
		.run_vec(run_vec),
		.adv_vec(adv_vec),
		.eff_len(eff_len),
		.overflow(ovf)
	);

	lwm_position_engine #(
		.PATTERN_MAX(PATTERN_MAX),
		.LW(LW)
	) u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(pos_cmd),
		.run_vec(run_vec),
		.adv_vec(adv_vec),
		.eff_len(eff_len),
		.matched(matched)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv_s1 && produce) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && produce) begin
			rsp_q.matched <= matched;
			rsp_q.pattern_overflow <= ovf;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	// a new result only comes from an end item leaving the input register
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(vld_s1 && (item_s1.action == ACT_END)))
		else $error("result raised without an end item");

	// the input side stalls only behind a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (produce && rsp_valid_q && rsp_stall))
		else $error("input stalled without a blocked result");

	// a clear empties the overflow flag
	a_clear_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && (item_s1.action == ACT_CLEAR)) |=> !ovf)
		else $error("overflow survived a clear");

endmodule

`default_nettype wire
